FILE: hw/rtl/rwpd_pkg.sv
package rwpd_pkg;

	localparam int FRAME_BITS = 36;
	localparam int CNT_W      = 6;
	localparam int ADDR_W     = 6;
	localparam int TBL_DEPTH  = 1 << ADDR_W;
	localparam int ENTRY_W    = 24;

	localparam logic CMD_PULSE = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	localparam logic REG_SHORT_LOW  = 1'b0;
	localparam logic REG_SHORT_HIGH = 1'b1;

	localparam logic [15:0] SHORT_LOW_RST  = 16'd750;
	localparam logic [15:0] SHORT_HIGH_RST = 16'd1250;

	localparam logic [3:0] SYNC0_MATCH = 4'd12;
	localparam logic [2:0] SYNC1_MATCH = 3'd6;

	localparam logic [19:0]        TEMP_SCALE = 20'd25;
	localparam int                 TEMP_SHIFT = 5;
	localparam logic signed [16:0] TEMP_BIAS  = 17'sd5000;

	localparam logic signed [8:0] HUMI_MIN = -9'sd128;
	localparam logic signed [8:0] HUMI_MAX = 9'sd254;

	typedef struct packed {
		logic [1:0]  id;
		logic [3:0]  unit;
		logic [6:0]  hraw;
		logic [14:0] traw;
	} frame_t;

endpackage

FILE: hw/rtl/rf_weather_pulse_decoder_unit.sv
// Channel    Direction  Handshake             Payload
// input      in         in_valid / in_ready   command, pulse_width, frame_start, entry_id,
//                                             entry_unit, temp_trim, humi_trim
// output     out        out_valid / out_ready sensor_id, sensor_unit, temperature, humidity
// config     in         cfg_write             cfg_index, cfg_data
//
// One transaction is taken per cycle while in_ready is high; a decoded frame passes
// from its last pulse through the offset table read stage and then the output register.
// The offset table is a 64-entry memory with one valid bit per entry; reset clears the
// valid bits at once, so no clearing pass is needed.
// The input stalls only while a result waits in the table read stage and the output
// register is full and not taken.
module rf_weather_pulse_decoder_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic                          cfg_index,
	input  logic [15:0]                   cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          command,
	input  logic [15:0]                   pulse_width,
	input  logic                          frame_start,
	input  logic [1:0]                    entry_id,
	input  logic [3:0]                    entry_unit,
	input  logic signed [15:0]            temp_trim,
	input  logic signed [7:0]             humi_trim,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    sensor_id,
	output logic [3:0]                    sensor_unit,
	output logic signed [16:0]            temperature,
	output logic signed [8:0]             humidity
);
	import rwpd_pkg::*;

	logic [15:0]           short_low_q;
	logic [15:0]           short_high_q;
	logic [FRAME_BITS-1:0] shift_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  skip_q;
	logic                  parity_q;
	logic                  done_q;

	logic [ENTRY_W-1:0]    mem [TBL_DEPTH];
	logic [TBL_DEPTH-1:0]  valid_q;

	logic                  v_s1;
	frame_t                frame_s1;
	logic [ENTRY_W-1:0]    ent_s1;
	logic                  entv_s1;

	logic                  accept;
	logic                  pulse_acc;
	logic                  wr_acc;
	logic                  out_free;
	logic                  done_e;
	logic                  skip_e;
	logic                  one_bit;
	logic                  take_bit;
	logic [FRAME_BITS-1:0] shift_n;
	logic [CNT_W-1:0]      cnt_n;
	logic                  parity_n;
	logic                  frame_end;
	logic                  sync_ok;
	logic                  fire;
	frame_t                frame_n;
	logic [ADDR_W-1:0]     rd_addr;
	logic [ADDR_W-1:0]     wr_addr;

	logic [19:0]           prod;
	logic [14:0]           tscaled;
	logic signed [15:0]    toff;
	logic signed [7:0]     hoff;
	logic signed [16:0]    temp_n;
	logic signed [8:0]     humi_n;

	assign out_free  = !out_valid || out_ready;
	assign in_ready  = !v_s1 || out_free;
	assign accept    = in_valid && in_ready;
	assign pulse_acc = accept && (command == CMD_PULSE);
	assign wr_acc    = accept && (command == CMD_WRITE);

	assign done_e    = frame_start ? 1'b0 : done_q;
	assign skip_e    = frame_start ? 1'b0 : skip_q;
	assign one_bit   = (pulse_width > short_low_q) && (pulse_width < short_high_q);
	assign take_bit  = !done_e && !skip_e;

	always_comb begin
		shift_n  = frame_start ? '0 : shift_q;
		cnt_n    = frame_start ? '0 : cnt_q;
		parity_n = frame_start ? 1'b0 : parity_q;
		if (take_bit) begin
			shift_n  = {shift_n[FRAME_BITS-2:0], one_bit};
			cnt_n    = cnt_n + CNT_W'(1);
			parity_n = parity_n ^ one_bit;
		end
	end

	assign frame_end = take_bit && (cnt_n >= CNT_W'(FRAME_BITS));
	assign sync_ok   = (shift_n[35:32] == SYNC0_MATCH) || (shift_n[25:23] == SYNC1_MATCH);
	assign fire      = pulse_acc && frame_end && !parity_n && sync_ok;

	assign frame_n.id   = shift_n[27:26];
	assign frame_n.unit = shift_n[31:28];
	assign frame_n.hraw = shift_n[22:16];
	assign frame_n.traw = shift_n[15:1];

	assign rd_addr = {frame_n.id, frame_n.unit};
	assign wr_addr = {entry_id, entry_unit};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_low_q  <= SHORT_LOW_RST;
			short_high_q <= SHORT_HIGH_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_SHORT_LOW:  short_low_q  <= cfg_data;
				REG_SHORT_HIGH: short_high_q <= cfg_data;
				default:        short_low_q  <= short_low_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q  <= '0;
			cnt_q    <= '0;
			skip_q   <= 1'b0;
			parity_q <= 1'b0;
			done_q   <= 1'b1;
		end else if (pulse_acc) begin
			shift_q  <= shift_n;
			cnt_q    <= cnt_n;
			parity_q <= parity_n;
			if (frame_end) begin
				done_q <= 1'b1;
				skip_q <= 1'b0;
			end else begin
				done_q <= done_e;
				skip_q <= take_bit ? one_bit : 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_acc) begin
			mem[wr_addr] <= {temp_trim, humi_trim};
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			ent_s1   <= mem[rd_addr];
			frame_s1 <= frame_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			entv_s1 <= 1'b0;
		end else begin
			if (wr_acc) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (fire) begin
				entv_s1 <= valid_q[rd_addr];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= fire;
		end
	end

	assign prod    = 20'(frame_s1.traw) * TEMP_SCALE;
	assign tscaled = prod[TEMP_SHIFT +: 15];
	assign toff    = entv_s1 ? $signed(ent_s1[23:8]) : 16'sd0;
	assign hoff    = entv_s1 ? $signed(ent_s1[7:0]) : 8'sd0;
	assign temp_n  = $signed({2'b00, tscaled}) - TEMP_BIAS + 17'(toff);
	assign humi_n  = $signed({2'b00, frame_s1.hraw}) + 9'(hoff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && v_s1) begin
			sensor_id   <= frame_s1.id;
			sensor_unit <= frame_s1.unit;
			temperature <= temp_n;
			humidity    <= humi_n;
		end
	end

endmodule

FILE: hw/rtl/rwpd_checker.sv
module rwpd_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  cfg_write,
	input logic                  cfg_index,
	input logic [15:0]           cfg_data,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  command,
	input logic [15:0]           pulse_width,
	input logic                  frame_start,
	input logic [1:0]            entry_id,
	input logic [3:0]            entry_unit,
	input logic signed [15:0]    temp_trim,
	input logic signed [7:0]     humi_trim,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [1:0]            sensor_id,
	input logic [3:0]            sensor_unit,
	input logic signed [16:0]    temperature,
	input logic signed [8:0]     humidity
);
	import rwpd_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sensor_id) && $stable(sensor_unit)
			&& $stable(temperature) && $stable(humidity))
		else $error("Result changed while stalled.");

	a_rise_from_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready && command == CMD_PULSE, 2))
		else $error("Result appeared without a pulse two cycles earlier.");

	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("Input stalled while output was being taken.");

	a_humi_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (humidity >= HUMI_MIN) && (humidity <= HUMI_MAX))
		else $error("Humidity out of range.");

endmodule

bind rf_weather_pulse_decoder_unit rwpd_checker u_rwpd_checker (.*);
